>>> design/fourier_series_evaluator_unit_macros.svh
// assertion helpers shared by the evaluator rtl
`ifndef FOURIER_SERIES_EVALUATOR_UNIT_MACROS_SVH
`define FOURIER_SERIES_EVALUATOR_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define FSE_ASSERT_IMPLY(label, clock, reset, lhs, rhs) \
  label: assert property (@(posedge clock) disable iff (reset) (lhs) |-> (rhs)) \
    else $error("fse same-cycle check failed");

// next-cycle implication, disabled during reset
`define FSE_ASSERT_NEXT(label, clock, reset, lhs, rhs) \
  label: assert property (@(posedge clock) disable iff (reset) (lhs) |=> (rhs)) \
    else $error("fse next-cycle check failed");

`endif

>>> design/fse_pkg.sv
package fse_pkg;

  // default sizes
  localparam int HARMONICS_DEF     = 16;
  localparam int SINE_ROM_BITS_DEF = 10;

  // field widths fixed by the interface
  localparam int COEF_W     = 32;
  localparam int CFG_DATA_W = 32;
  localparam int SINE_W     = 17;

  // function codes
  localparam logic [1:0] FUNC_LOAD = 2'd0;
  localparam logic [1:0] FUNC_EVAL = 2'd1;
  localparam logic [1:0] FUNC_READ = 2'd2;

  // configuration register indexes
  localparam logic CFG_NUM_TERMS  = 1'b0;
  localparam logic CFG_INV_PERIOD = 1'b1;

  // register reset values
  localparam logic [4:0]  NUM_TERMS_RST  = 5'd1;
  localparam logic [31:0] INV_PERIOD_RST = 32'd65536;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_DONE,
    S_EV_A0,
    S_EV_RUN,
    S_EV_DRAIN,
    S_EV_DONE
  } state_t;

  // taylor series constants
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint TAYLOR_DIV [10] = '{6, 20, 42, 72, 110, 156, 210, 272, 342, 420};

  // one quarter-wave sine entry in q1.16, evaluated at elaboration
  function automatic logic [SINE_W-1:0] sine_rom_entry(int rom_bits, int k);
    longint theta;
    longint theta2;
    longint term;
    longint sum;
    longint r;
    theta  = (HALF_PI_Q30 * longint'(k)) >>> rom_bits;
    theta2 = (theta * theta) >>> 30;
    term   = theta;
    sum    = theta;
    for (int n = 1; n <= 10; n++) begin
      term = (term * theta2) >>> 30;
      term = term / TAYLOR_DIV[n-1];
      if ((n % 2) == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    r = (sum + 8192) >>> 14;
    if (r > 65536) begin
      r = 65536;
    end
    return SINE_W'(r);
  endfunction

endpackage

>>> design/fourier_series_evaluator_unit.sv
// Truncated Fourier series evaluator. A load transaction (func 0) writes one
// cosine/sine coefficient pair and returns no result; the block stays idle.
// A read transaction (func 2) returns the stored pair, or index_error when the
// index is at or beyond the term count in use; its result is registered from
// S_RD_DONE once the output slot is free, and the block then returns to idle.
// An evaluate transaction (func 1) returns a0/2 + sum(a_i*cos + b_i*sin) for
// i = 1 .. n-1, truncated toward zero, where n = min(num_terms, HARMONICS); it
// steps through S_EV_A0, which seeds the accumulator with a0/2, S_EV_RUN, one
// pass per harmonic through the shared two-product multiply-accumulate lane
// fed from the coefficient memory and the quarter-wave sine ROM, S_EV_DRAIN
// and S_EV_DONE, which registers the result once the output slot is free.
// The block is busy while an item is in flight; a finished result waits in
// the output register while the next transaction is accepted. The phase is
// the 16-bit turn fraction of x_point * inv_period, advanced by addition for
// each harmonic. The coefficient table reads as zero after reset.
`include "fourier_series_evaluator_unit_macros.svh"

module fourier_series_evaluator_unit
  import fse_pkg::*;
#(
  parameter int HARMONICS     = HARMONICS_DEF,
  parameter int SINE_ROM_BITS = SINE_ROM_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // configuration port
  input  logic                         cfg_write,
  input  logic                         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  // input channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   func,
  input  logic [4:0]                   coef_index,
  input  logic signed [COEF_W-1:0]     cos_value,
  input  logic signed [COEF_W-1:0]     sin_value,
  input  logic signed [COEF_W-1:0]     x_point,
  // output channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COEF_W-1:0]     series_value,
  output logic signed [COEF_W-1:0]     cos_out,
  output logic signed [COEF_W-1:0]     sin_out,
  output logic                         index_error
);

  localparam int AW       = (HARMONICS > 1) ? $clog2(HARMONICS) : 1;
  localparam int CW       = $clog2(HARMONICS + 1);
  localparam int IW       = (AW > 5) ? AW : 5;
  localparam int ROM_SIZE = (1 << SINE_ROM_BITS) + 1;
  localparam int RAW      = SINE_ROM_BITS + 1;
  localparam int PROD_W   = COEF_W + SINE_W + 1;

  // state
  state_t state, state_next;

  // configuration registers
  logic [4:0]  num_terms;
  logic [31:0] inv_period;

  // coefficient memory with reset-cleared valid bits
  logic [2*COEF_W-1:0] coef_mem [HARMONICS];
  logic [HARMONICS-1:0] coef_vld;
  logic [2*COEF_W-1:0] rd_data;
  logic                rd_vld;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic                rd_err;

  // constant quarter-wave sine table
  logic [SINE_W-1:0] sine_rom [ROM_SIZE];
  logic [SINE_W-1:0] rom_cos_q, rom_sin_q;
  logic              neg_cos_q, neg_sin_q;

  // evaluation datapath
  logic [15:0]              base_phase;
  logic [15:0]              ph;
  logic [CW-1:0]            harm;
  logic                     p1, p2;
  logic signed [PROD_W-1:0] prod_c, prod_s;
  logic signed [63:0]       acc;

  // misc control
  logic [CW-1:0] eff;
  logic [IW-1:0] idx_w;
  logic          accept;
  logic          slot_free;
  logic          issue;
  logic          write_out;
  logic [31:0]   phase_prod;

  // build the sine table at elaboration
  genvar k;
  for (k = 0; k < ROM_SIZE; k++) begin : g_rom
    assign sine_rom[k] = sine_rom_entry(SINE_ROM_BITS, k);
  end

  // effective term count
  always_comb begin
    if (num_terms >= HARMONICS) begin
      eff = CW'(HARMONICS);
    end else begin
      eff = CW'(num_terms);
    end
  end

  assign idx_w      = IW'(coef_index);
  assign accept     = in_valid && in_ready;
  assign slot_free  = !out_valid || out_ready;
  assign phase_prod = $unsigned(x_point) * inv_period;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (func)
            FUNC_EVAL: state_next = S_EV_A0;
            FUNC_READ: state_next = S_RD_DONE;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_RD_DONE: begin
        if (slot_free) state_next = S_IDLE;
      end
      S_EV_A0: begin
        state_next = (eff > CW'(1)) ? S_EV_RUN : S_EV_DRAIN;
      end
      S_EV_RUN: begin
        if (({1'b0, harm} + (CW+1)'(1)) >= {1'b0, eff}) state_next = S_EV_DRAIN;
      end
      S_EV_DRAIN: begin
        if (!p1) state_next = S_EV_DONE;
      end
      S_EV_DONE: begin
        if (slot_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready  = (state == S_IDLE);
    rd_en     = 1'b0;
    rd_addr   = '0;
    issue     = 1'b0;
    write_out = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid && func == FUNC_EVAL) begin
          rd_en = 1'b1;
        end else if (in_valid && func == FUNC_READ) begin
          rd_en   = 1'b1;
          rd_addr = idx_w[AW-1:0];
        end
      end
      S_EV_RUN: begin
        rd_en   = 1'b1;
        rd_addr = harm[AW-1:0];
        issue   = 1'b1;
      end
      S_RD_DONE, S_EV_DONE: begin
        write_out = slot_free;
      end
      default: ;
    endcase
  end

  // rom addresses for the current phase, cosine a quarter turn ahead
  logic [15:0]    ph_cos;
  logic [RAW-1:0] sin_addr, cos_addr;
  assign ph_cos = ph + 16'h4000;

  always_comb begin
    sin_addr = {1'b0, ph[13 -: SINE_ROM_BITS]};
    if (ph[14]) sin_addr = RAW'(ROM_SIZE - 1) - sin_addr;
    cos_addr = {1'b0, ph_cos[13 -: SINE_ROM_BITS]};
    if (ph_cos[14]) cos_addr = RAW'(ROM_SIZE - 1) - cos_addr;
  end

  // signed sine values and masked coefficients for the multiply stage
  logic signed [SINE_W:0]   s_cos, s_sin;
  logic signed [COEF_W-1:0] a_i, b_i;
  always_comb begin
    s_cos = $signed({1'b0, rom_cos_q});
    s_sin = $signed({1'b0, rom_sin_q});
    if (neg_cos_q) s_cos = -s_cos;
    if (neg_sin_q) s_sin = -s_sin;
    a_i = rd_vld ? $signed(rd_data[2*COEF_W-1:COEF_W]) : '0;
    b_i = rd_vld ? $signed(rd_data[COEF_W-1:0]) : '0;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      num_terms  <= NUM_TERMS_RST;
      inv_period <= INV_PERIOD_RST;
      coef_vld   <= '0;
      out_valid  <= 1'b0;
      p1         <= 1'b0;
      p2         <= 1'b0;
    end else begin
      state <= state_next;
      p1    <= issue;
      p2    <= p1;
      if (cfg_write) begin
        case (cfg_index)
          CFG_NUM_TERMS:  num_terms  <= cfg_data[4:0];
          CFG_INV_PERIOD: inv_period <= cfg_data;
          default: ;
        endcase
      end
      if (accept && func == FUNC_LOAD && coef_index < HARMONICS) begin
        coef_vld[idx_w[AW-1:0]] <= 1'b1;
      end
      if (write_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // coefficient memory write and registered read
  always_ff @(posedge clk) begin
    if (accept && func == FUNC_LOAD && coef_index < HARMONICS) begin
      coef_mem[idx_w[AW-1:0]] <= {cos_value, sin_value};
    end
    if (rd_en) begin
      rd_data <= coef_mem[rd_addr];
      rd_vld  <= coef_vld[rd_addr];
    end
  end

  // rom read, phase tracking and multiply-accumulate lane
  always_ff @(posedge clk) begin
    rom_sin_q <= sine_rom[sin_addr];
    rom_cos_q <= sine_rom[cos_addr];
    neg_sin_q <= ph[15];
    neg_cos_q <= ph_cos[15];

    if (accept) begin
      base_phase <= phase_prod[31:16];
      rd_err     <= !(coef_index < eff);
    end

    // constant term seeds the accumulator
    if (state == S_EV_A0) begin
      acc  <= {{17{a_i[COEF_W-1]}}, a_i, 15'b0};
      ph   <= base_phase;
      harm <= CW'(1);
    end else if (p2) begin
      acc <= acc + 64'(prod_c) + 64'(prod_s);
    end

    if (issue) begin
      ph   <= ph + base_phase;
      harm <= harm + CW'(1);
    end

    if (p1) begin
      prod_c <= PROD_W'(a_i * s_cos);
      prod_s <= PROD_W'(b_i * s_sin);
    end

    // result register; the 64-bit sum divided by 2^32 always fits 32 bits
    if (write_out) begin
      if (state == S_RD_DONE) begin
        series_value <= '0;
        index_error  <= rd_err;
        cos_out      <= (rd_err || !rd_vld) ? '0 : $signed(rd_data[2*COEF_W-1:COEF_W]);
        sin_out      <= (rd_err || !rd_vld) ? '0 : $signed(rd_data[COEF_W-1:0]);
      end else begin
        if (acc[63]) begin
          series_value <= 32'($signed(64'(acc + 64'sh0000_0000_FFFF_FFFF) >>> 32));
        end else begin
          series_value <= $signed(acc[63:32]);
        end
        index_error <= 1'b0;
        cos_out     <= '0;
        sin_out     <= '0;
      end
    end
  end

  // checks
  `FSE_ASSERT_IMPLY(a_idle_pipe_empty, clk, rst, in_ready, !p1 && !p2)
  `FSE_ASSERT_IMPLY(a_pipe_in_eval, clk, rst, p1, state == S_EV_RUN || state == S_EV_DRAIN)
  `FSE_ASSERT_IMPLY(a_error_zero_payload, clk, rst, out_valid && index_error,
                    cos_out == 0 && sin_out == 0 && series_value == 0)
  `FSE_ASSERT_NEXT(a_done_holds, clk, rst, state == S_EV_DONE && out_valid && !out_ready,
                   state == S_EV_DONE)

endmodule
